// ===== src/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// shared widths, types and constants of the servo target interpolator
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int PULSE_W   = 16;
  localparam int TICK_BITS = 16;
  localparam int PROD_W    = PULSE_W + TICK_BITS;
  localparam int CNT_W     = $clog2(PROD_W);

  typedef logic [PULSE_W-1:0]   pulse_t;
  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam pulse_t PULSE_RESET = PULSE_W'(1500);

endpackage

// ===== src/sti_if.sv =====
// ----------------------------------------------------------------------------
// sti_in_if / sti_out_if
// valid/ready channels carrying control ticks and smoothed pulse pairs
// ----------------------------------------------------------------------------
interface sti_in_if;
  logic            valid;
  logic            ready;
  logic            has_command;
  sti_pkg::pulse_t pan_target;
  sti_pkg::pulse_t tilt_target;

  modport source (output valid, has_command, pan_target, tilt_target, input ready);
  modport sink   (input valid, has_command, pan_target, tilt_target, output ready);
endinterface

interface sti_out_if;
  logic            valid;
  logic            ready;
  sti_pkg::pulse_t pan_pulse;
  sti_pkg::pulse_t tilt_pulse;

  modport source (output valid, pan_pulse, tilt_pulse, input ready);
  modport sink   (input valid, pan_pulse, tilt_pulse, output ready);
endinterface

// ===== src/sti_muldiv.sv =====
// ----------------------------------------------------------------------------
// sti_muldiv
// bit-serial blend: base + floor((goal - base) * step / span)
// ----------------------------------------------------------------------------
module sti_muldiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  sti_pkg::pulse_t base,
  input  sti_pkg::pulse_t goal,
  input  sti_pkg::tick_t  step,
  input  sti_pkg::tick_t  span,
  output logic            done,
  output sti_pkg::pulse_t pulse
);
  import sti_pkg::*;

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV, P_FIN} phase_t;

  phase_t                   phase_r, phase_nxt;
  cnt_t                     cnt_r, cnt_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  tick_t                    rem_r, rem_nxt;
  tick_t                    span_r, span_nxt;
  pulse_t                   mag_r, mag_nxt;
  pulse_t                   base_r, base_nxt;
  logic                     neg_r, neg_nxt;
  logic                     done_r, done_nxt;
  pulse_t                   pulse_r, pulse_nxt;

  logic [PULSE_W:0]         diff;
  logic [PULSE_W:0]         diff_mag;
  logic [PULSE_W:0]         add_sum;
  logic [TICK_BITS:0]       trial;
  logic                     ge;
  tick_t                    trial_sub;
  pulse_t                   quo;

  always_comb begin
    diff      = {1'b0, goal} - {1'b0, base};
    diff_mag  = diff[PULSE_W] ? (~diff + 1'b1) : diff;
    // shift-add multiply step, one multiplier bit per cycle
    add_sum   = {1'b0, prod_r[PROD_W-1:TICK_BITS]} + (prod_r[0] ? {1'b0, mag_r} : '0);
    // restoring divide step, one quotient bit per cycle
    trial     = {rem_r, prod_r[PROD_W-1]};
    ge        = (trial >= {1'b0, span_r});
    trial_sub = TICK_BITS'(trial - {1'b0, span_r});
    quo       = prod_r[PULSE_W-1:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    mag_nxt   = mag_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    pulse_nxt = pulse_r;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          mag_nxt   = diff_mag[PULSE_W-1:0];
          neg_nxt   = diff[PULSE_W];
          base_nxt  = base;
          span_nxt  = span;
          prod_nxt  = {{PULSE_W{1'b0}}, step};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = P_MUL;
        end
      end
      P_MUL: begin
        prod_nxt = {add_sum, prod_r[TICK_BITS-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TICK_BITS - 1)) begin
          cnt_nxt   = '0;
          phase_nxt = P_DIV;
        end
      end
      P_DIV: begin
        rem_nxt  = ge ? trial_sub : trial[TICK_BITS-1:0];
        prod_nxt = {prod_r[PROD_W-2:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          cnt_nxt   = '0;
          phase_nxt = P_FIN;
        end
      end
      P_FIN: begin
        // negative slope rounds toward minus infinity
        pulse_nxt = neg_r ? (base_r - quo - PULSE_W'(rem_r != '0)) : (base_r + quo);
        done_nxt  = 1'b1;
        phase_nxt = P_IDLE;
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    span_r  <= span_nxt;
    mag_r   <= mag_nxt;
    base_r  <= base_nxt;
    neg_r   <= neg_nxt;
    pulse_r <= pulse_nxt;
  end

  assign done  = done_r;
  assign pulse = pulse_r;

endmodule

// ===== src/servo_target_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// servo_target_interpolator_top
// linear setpoint interpolation of pan and tilt servo pulses, one tick per item
// ----------------------------------------------------------------------------
// Each input transfer is one control tick, optionally carrying a new pan/tilt
// target; each tick gives exactly one output transfer with the smoothed pulse
// pair. The block works on one tick at a time. A tick with no motion, a zero
// span or a step at or past the span goes from S_IDLE straight to S_PUSH, which
// loads the output register once it is free, then back to S_IDLE. A tick that
// needs a blend waits in S_CALC while both axes run through bit-serial
// multiply/divide units in parallel: a shift-add multiply over the TICK_BITS
// multiplier bits, then a restoring divide over the PULSE_W + TICK_BITS bits of
// the product; S_PUSH then takes the blended pair to the output register.
// The next tick is taken once the result sits in the output register; it may
// be taken while that result still waits to be transferred.
// ----------------------------------------------------------------------------
module servo_target_interpolator_top (
  input  logic       clk,
  input  logic       rst_n,
  sti_in_if.sink     in_ch,
  sti_out_if.source  out_ch
);
  import sti_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_PUSH} state_t;

  state_t state_r, state_nxt;

  // interpolation state
  tick_t  tick_r, tick_nxt;
  tick_t  last_r, last_nxt;
  tick_t  span_r, span_nxt;
  tick_t  step_r, step_nxt;
  logic   pend_r, pend_nxt;
  pulse_t start_pan_r, start_pan_nxt;
  pulse_t start_tilt_r, start_tilt_nxt;
  pulse_t goal_pan_r, goal_pan_nxt;
  pulse_t goal_tilt_r, goal_tilt_nxt;
  pulse_t cur_pan_r, cur_pan_nxt;
  pulse_t cur_tilt_r, cur_tilt_nxt;

  // blend unit kick and output register
  logic   calc_go_r, calc_go_nxt;
  logic   out_valid_r, out_valid_nxt;
  pulse_t out_pan_r, out_pan_nxt;
  pulse_t out_tilt_r, out_tilt_nxt;

  logic   accept;
  logic   pend_eff;
  logic   restart;
  tick_t  span_eff;
  tick_t  step_eff;
  tick_t  step_inc;
  logic   moving;
  logic   pan_done, tilt_done;
  pulse_t pan_blend, tilt_blend;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    last_nxt       = last_r;
    span_nxt       = span_r;
    step_nxt       = step_r;
    pend_nxt       = pend_r;
    start_pan_nxt  = start_pan_r;
    start_tilt_nxt = start_tilt_r;
    goal_pan_nxt   = goal_pan_r;
    goal_tilt_nxt  = goal_tilt_r;
    cur_pan_nxt    = cur_pan_r;
    cur_tilt_nxt   = cur_tilt_r;
    calc_go_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_pan_nxt    = out_pan_r;
    out_tilt_nxt   = out_tilt_r;

    // tick bookkeeping, all on the arriving item
    if (accept && in_ch.has_command) begin
      goal_pan_nxt  = in_ch.pan_target;
      goal_tilt_nxt = in_ch.tilt_target;
    end
    pend_eff = pend_r || in_ch.has_command;
    restart  = pend_eff && (tick_r != last_r);
    span_eff = restart ? (tick_r - last_r) : span_r;
    step_eff = restart ? '0 : step_r;
    // saturating step counter
    step_inc = (step_eff == '1) ? step_eff : (step_eff + 1'b1);
    moving   = (cur_pan_r != goal_pan_nxt) || (cur_tilt_r != goal_tilt_nxt);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tick_nxt  = tick_r + 1'b1;
          pend_nxt  = pend_eff && !restart;
          span_nxt  = span_eff;
          step_nxt  = step_eff;
          state_nxt = S_PUSH;
          if (restart) begin
            last_nxt       = tick_r;
            start_pan_nxt  = cur_pan_r;
            start_tilt_nxt = cur_tilt_r;
          end
          if (moving) begin
            step_nxt = step_inc;
            if (span_eff != '0) begin
              if (step_inc >= span_eff) begin
                // past the end of the ramp: land on the goal
                cur_pan_nxt  = goal_pan_nxt;
                cur_tilt_nxt = goal_tilt_nxt;
              end else begin
                calc_go_nxt = 1'b1;
                state_nxt   = S_CALC;
              end
            end
          end
        end
      end
      S_CALC: begin
        if (pan_done && tilt_done) begin
          cur_pan_nxt  = pan_blend;
          cur_tilt_nxt = tilt_blend;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pan_nxt   = cur_pan_r;
          out_tilt_nxt  = cur_tilt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= '0;
      last_r       <= '0;
      span_r       <= '0;
      step_r       <= '0;
      pend_r       <= 1'b0;
      start_pan_r  <= PULSE_RESET;
      start_tilt_r <= PULSE_RESET;
      goal_pan_r   <= PULSE_RESET;
      goal_tilt_r  <= PULSE_RESET;
      cur_pan_r    <= PULSE_RESET;
      cur_tilt_r   <= PULSE_RESET;
      calc_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      last_r       <= last_nxt;
      span_r       <= span_nxt;
      step_r       <= step_nxt;
      pend_r       <= pend_nxt;
      start_pan_r  <= start_pan_nxt;
      start_tilt_r <= start_tilt_nxt;
      goal_pan_r   <= goal_pan_nxt;
      goal_tilt_r  <= goal_tilt_nxt;
      cur_pan_r    <= cur_pan_nxt;
      cur_tilt_r   <= cur_tilt_nxt;
      calc_go_r    <= calc_go_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_pan_r  <= out_pan_nxt;
    out_tilt_r <= out_tilt_nxt;
  end

  // one serial blend unit per axis, started together so they finish together
  sti_muldiv u_pan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_go_r),
    .base  (start_pan_r),
    .goal  (goal_pan_r),
    .step  (step_r),
    .span  (span_r),
    .done  (pan_done),
    .pulse (pan_blend)
  );

  sti_muldiv u_tilt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_go_r),
    .base  (start_tilt_r),
    .goal  (goal_tilt_r),
    .step  (step_r),
    .span  (span_r),
    .done  (tilt_done),
    .pulse (tilt_blend)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pan_pulse  = out_pan_r;
  assign out_ch.tilt_pulse = out_tilt_r;

endmodule

// ===== dv/sti_pulse_monitor.sv =====
// ----------------------------------------------------------------------------
// sti_pulse_monitor
// watches both channels, predicts each tick's pulse pair and compares
// ----------------------------------------------------------------------------
// Every tick taken on the input channel advances a private copy of the
// interpolator state and queues the pulse pair it should produce. Every pair
// taken on the output channel is checked against the oldest queued pair.
// ----------------------------------------------------------------------------
module sti_pulse_monitor (
  input  logic clk,
  input  logic rst_n,
  sti_in_if    in_ch,
  sti_out_if   out_ch,
  output int   mismatches,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sti_pkg::*;

  typedef struct packed {
    pulse_t pan;
    pulse_t tilt;
  } pulse_pair_t;

  tick_t       tick_cnt;
  tick_t       restart_tick;
  tick_t       span;
  tick_t       step;
  logic        restart_due;
  pulse_t      start_pan, start_tilt;
  pulse_t      goal_pan, goal_tilt;
  pulse_t      cur_pan, cur_tilt;
  pulse_pair_t pairs_owed[$];
  int          mismatch_cnt;

  // start + floor((goal - start) * step / span), clamped to goal at the end
  function automatic pulse_t blend_axis(pulse_t origin, pulse_t goal, tick_t stp,
                                        tick_t spn);
    longint diff, prod, quot;
    if (stp >= spn) return goal;
    diff = longint'(goal) - longint'(origin);
    prod = diff * longint'(stp);
    if (prod >= 0) quot = prod / longint'(spn);
    else quot = -((-prod + longint'(spn) - 1) / longint'(spn));
    return pulse_t'(longint'(origin) + quot);
  endfunction

  function void advance_tick(logic cmd, pulse_t pan_tgt, pulse_t tilt_tgt);
    if (cmd) begin
      goal_pan    = pan_tgt;
      goal_tilt   = tilt_tgt;
      restart_due = 1'b1;
    end
    if (restart_due && tick_cnt != restart_tick) begin
      span         = tick_cnt - restart_tick;
      restart_tick = tick_cnt;
      start_pan    = cur_pan;
      start_tilt   = cur_tilt;
      step         = '0;
      restart_due  = 1'b0;
    end
    if (cur_pan != goal_pan || cur_tilt != goal_tilt) begin
      if (step != '1) step = step + 1'b1;
      // zero span holds the pulses
      if (span != '0) begin
        cur_pan  = blend_axis(start_pan, goal_pan, step, span);
        cur_tilt = blend_axis(start_tilt, goal_tilt, step, span);
      end
    end
    pairs_owed.push_back({cur_pan, cur_tilt});
    tick_cnt = tick_cnt + 1'b1;
  endfunction

  always @(posedge clk) begin
    pulse_pair_t want;
    if (!rst_n) begin
      tick_cnt     = '0;
      restart_tick = '0;
      span         = '0;
      step         = '0;
      restart_due  = 1'b0;
      start_pan    = PULSE_RESET;
      start_tilt   = PULSE_RESET;
      goal_pan     = PULSE_RESET;
      goal_tilt    = PULSE_RESET;
      cur_pan      = PULSE_RESET;
      cur_tilt     = PULSE_RESET;
      pairs_owed.delete();
      mismatch_cnt = 0;
    end else begin
      // a result can never leave in the cycle its tick arrives, so check first
      if (out_ch.valid && out_ch.ready) begin
        if (pairs_owed.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result pan %0d tilt %0d", $time,
                   out_ch.pan_pulse, out_ch.tilt_pulse);
        end else begin
          want = pairs_owed.pop_front();
          if (out_ch.pan_pulse !== want.pan || out_ch.tilt_pulse !== want.tilt) begin
            mismatch_cnt++;
            $display("%0t: pulse mismatch, expected pan %0d tilt %0d, actual pan %0d tilt %0d",
                     $time, want.pan, want.tilt, out_ch.pan_pulse, out_ch.tilt_pulse);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        advance_tick(in_ch.has_command, in_ch.pan_target, in_ch.tilt_target);
    end
    mismatches   <= mismatch_cnt;
    results_owed <= pairs_owed.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the servo target interpolator
// ----------------------------------------------------------------------------
// Sends control ticks: a directed opening, random target moves with and without
// random idling on both channels, a long output hold-off, and a few closing moves.
// The pulse monitor predicts and checks each result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sti_pkg::*;

  // longest legal quiet stretch is the hold-off plus one blend and two bursts
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic  clk;
  logic  rst_n;
  logic  src_idle_on;
  logic  sink_idle_on;
  logic  hold_req;
  int    fail_cnt;
  int    owed_cnt;
  int    quiet_cycles = 0;

  sti_in_if  in_ch();
  sti_out_if out_ch();

  servo_target_interpolator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sti_pulse_monitor u_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (fail_cnt),
    .results_owed (owed_cnt)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // targets: rails, the usual servo range, or anything
  function automatic pulse_t pick_pulse();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return pulse_t'($urandom_range(900, 2100));
      default: return pulse_t'($urandom);
    endcase
  endfunction

  // one tick, optionally preceded by an idle burst; returns at the transfer edge
  task automatic send_tick(input logic cmd, input pulse_t pan, input pulse_t tilt);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.has_command <= cmd;
    in_ch.pan_target  <= pan;
    in_ch.tilt_target <= tilt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // a command, sometimes two back to back, then a random run of plain ticks;
  // the run length sets the span of the next move
  task automatic random_moves(input int n_ticks);
    int sent;
    int coast;
    sent = 0;
    while (sent < n_ticks) begin
      send_tick(1'b1, pick_pulse(), pick_pulse());
      sent++;
      if ($urandom_range(0, 5) == 0) begin
        send_tick(1'b1, pick_pulse(), pick_pulse());
        sent++;
      end
      case ($urandom_range(0, 9))
        0: coast = 0;
        7, 8: coast = $urandom_range(9, 40);
        9: coast = $urandom_range(41, 160);
        default: coast = $urandom_range(1, 8);
      endcase
      repeat (coast) begin
        send_tick(1'b0, pulse_t'($urandom), pulse_t'($urandom));
        sent++;
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (owed_cnt != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, or one long hold-off on request
  initial begin
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held         = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.has_command = 1'b0;
    in_ch.pan_target  = '0;
    in_ch.tilt_target = '0;
    rst_n             = 1'b0;
    src_idle_on       = 1'b0;
    sink_idle_on      = 1'b0;
    hold_req          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // command on tick 0: tick equals the last restart tick, so the restart
    // waits one tick and the zero span holds the pulses
    send_tick(1'b1, 16'd1000, 16'd2000);
    // restart with span 1, ignored payload at the rails
    send_tick(1'b0, '1, '1);
    // full-scale jumps in both directions
    send_tick(1'b1, '1, '0);
    repeat (4) send_tick(1'b0, '0, '0);
    send_tick(1'b1, '0, '1);
    repeat (2) send_tick(1'b0, '1, '0);
    // retarget in mid-move, then coast until the step meets the span
    send_tick(1'b1, PULSE_RESET, PULSE_RESET);
    repeat (3) send_tick(1'b0, '0, '1);
    // back-to-back commands around the midpoint
    send_tick(1'b1, 16'h8000, 16'h7fff);
    send_tick(1'b1, 16'h7fff, 16'h8000);
    repeat (4) send_tick(1'b0, '0, '0);
    // two-count moves exercise floor rounding on both signs
    send_tick(1'b1, 16'h8001, 16'h7ffe);
    repeat (4) send_tick(1'b0, '0, '0);

    // random moves with idling on both sides
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    random_moves(600);

    // long hold-off on the result side while ticks keep coming, so the
    // block fills and stalls its input; then the sender waits for all results
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_req    <= 1'b1;
    repeat (8) send_tick(1'b1, pick_pulse(), pick_pulse());
    in_ch.valid <= 1'b0;
    wait_drained();

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    random_moves(600);

    // last part without any idling
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_moves(650);

    // a few closing moves with short spans
    send_tick(1'b1, pick_pulse(), pick_pulse());
    send_tick(1'b1, pick_pulse(), pick_pulse());
    repeat (3) send_tick(1'b0, pulse_t'($urandom), pulse_t'($urandom));
    send_tick(1'b1, pick_pulse(), pick_pulse());
    repeat (6) send_tick(1'b0, pulse_t'($urandom), pulse_t'($urandom));
    in_ch.valid <= 1'b0;

    // drain, then give a stray result time to show up
    wait_drained();
    repeat (64) @(posedge clk);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sti_pkg.sv
src/sti_if.sv
src/sti_muldiv.sv
src/servo_target_interpolator_top.sv
dv/sti_pulse_monitor.sv
dv/tb_top.sv
